>>> hdl/fern_pkg.sv
// ----------------------------------------------------------------------------
// Fern IFS package
// Shared types, constants and map tables for the fern point generator.
// ----------------------------------------------------------------------------
`default_nettype none

package fern_pkg;

  // Field widths fixed by the interface
  localparam int PICK_W     = 7;
  localparam int CFG_W      = 12;
  localparam int CFG_IDX_W  = 2;

  // Map coefficients: signed, 16 fraction bits
  localparam int COEF_W     = 17;
  localparam int COEF_FRAC  = 16;

  // Pick thresholds
  localparam logic [PICK_W-1:0] PICK_MAIN  = 7'd1;
  localparam logic [PICK_W-1:0] PICK_LEFT  = 7'd86;
  localparam logic [PICK_W-1:0] PICK_RIGHT = 7'd93;

  // Register reset values
  localparam logic [CFG_W-1:0] PLOT_LEFT_RST = 12'd110;
  localparam logic [CFG_W-1:0] PLOT_TOP_RST  = 12'd30;
  localparam logic [CFG_W-1:0] PLOT_SIZE_RST = 12'd420;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PLOT_LEFT = 2'd0,
    CFG_PLOT_TOP  = 2'd1,
    CFG_PLOT_SIZE = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MAP_STEM  = 2'd0,
    MAP_MAIN  = 2'd1,
    MAP_LEFT  = 2'd2,
    MAP_RIGHT = 2'd3
  } map_e;

  typedef struct packed {
    logic signed [COEF_W-1:0] xx;
    logic signed [COEF_W-1:0] xy;
    logic signed [COEF_W-1:0] yx;
    logic signed [COEF_W-1:0] yy;
  } coef_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;   // latch pick, form the four point products
    logic point;  // sum, round, saturate, store new point
    logic scale;  // form the screen scaling products
    logic num;    // form the pixel numerators
    logic emit;   // divide, clamp, write the output register
  } ctl_cmd_t;

  function automatic map_e pick_to_map(input logic [PICK_W-1:0] pick);
    map_e m;
    priority if (pick < PICK_MAIN)  m = MAP_STEM;
    else if (pick < PICK_LEFT)      m = MAP_MAIN;
    else if (pick < PICK_RIGHT)     m = MAP_LEFT;
    else                            m = MAP_RIGHT;
    return m;
  endfunction

  function automatic coef_t map_coef(input map_e m);
    coef_t c;
    unique case (m)
      MAP_STEM:  c = '{xx: 17'sd0,     xy: 17'sd0,      yx: 17'sd0,     yy: 17'sd10486};
      MAP_MAIN:  c = '{xx: 17'sd55706, xy: 17'sd2621,   yx: -17'sd2621, yy: 17'sd55706};
      MAP_LEFT:  c = '{xx: 17'sd13107, xy: -17'sd17039, yx: 17'sd15073, yy: 17'sd14418};
      MAP_RIGHT: c = '{xx: -17'sd9830, xy: 17'sd18350,  yx: 17'sd17039, yy: 17'sd15729};
      default:   c = '0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

>>> hdl/fern_if.sv
// ----------------------------------------------------------------------------
// Fern IFS channel interfaces
// Valid/ready request channels for picks in and pixels out.
// ----------------------------------------------------------------------------
`default_nettype none

interface fern_pick_if;
  logic                        valid;
  logic                        ready;
  logic [fern_pkg::PICK_W-1:0] random_pick;

  modport source (output valid, output random_pick, input ready);
  modport sink   (input valid, input random_pick, output ready);
endinterface

interface fern_pixel_if #(
  parameter int SCREEN_BITS = 12
);
  logic                   valid;
  logic                   ready;
  logic [SCREEN_BITS-1:0] pixel_x;
  logic [SCREEN_BITS-1:0] pixel_y;
  logic                   clamped;

  modport source (output valid, output pixel_x, output pixel_y, output clamped,
                  input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, input clamped,
                  output ready);
endinterface

`default_nettype wire

>>> hdl/fern_ctrl.sv
// ----------------------------------------------------------------------------
// Fern IFS controller
// Sequences one request through the datapath and owns the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module fern_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output fern_pkg::ctl_cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_POINT,
    S_SCALE,
    S_NUM,
    S_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   can_emit;
  logic   in_accept;

  assign can_emit   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) || ((state_q == S_EMIT) && can_emit);
  assign in_accept  = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          cmd_o.load = 1'b1;
          state_d    = S_POINT;
        end
      end
      S_POINT: begin
        cmd_o.point = 1'b1;
        state_d     = S_SCALE;
      end
      S_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = S_NUM;
      end
      S_NUM: begin
        cmd_o.num = 1'b1;
        state_d   = S_EMIT;
      end
      S_EMIT: begin
        if (can_emit) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          // next request may enter as this one leaves
          if (in_accept) begin
            cmd_o.load = 1'b1;
            state_d    = S_POINT;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // checks
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> !in_ready_o)
    else $error("input taken while a request is in flight");

  a_valid_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_EMIT))
    else $error("output valid rose outside the emit step");

  a_point_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.point |-> $past(cmd_o.load))
    else $error("point update without a loaded request");

  a_emit_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |=> out_valid_q)
    else $error("emitted result not flagged valid");

  a_one_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.point, cmd_o.scale, cmd_o.num, cmd_o.emit}))
    else $error("more than one datapath step at once");

endmodule

`default_nettype wire

>>> hdl/fern_dp.sv
// ----------------------------------------------------------------------------
// Fern IFS datapath
// Point recurrence, plot registers, screen scaling and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fern_dp #(
  parameter int COORD_BITS  = 24,
  parameter int FRAC_BITS   = 16,
  parameter int SCREEN_BITS = 12
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire fern_pkg::ctl_cmd_t              cmd_i,
  input  wire logic [fern_pkg::PICK_W-1:0]     random_pick_i,
  input  wire logic                            cfg_we_i,
  input  wire logic [fern_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [fern_pkg::CFG_W-1:0]      cfg_wdata_i,
  output logic      [SCREEN_BITS-1:0]          pixel_x_o,
  output logic      [SCREEN_BITS-1:0]          pixel_y_o,
  output logic                                 clamped_o
);

  localparam int CB  = COORD_BITS;
  localparam int FB  = FRAC_BITS;
  localparam int SB  = SCREEN_BITS;
  localparam int PW  = CB + fern_pkg::COEF_W;          // point product
  localparam int SW  = PW + 1;                          // sum of two products
  localparam int RW  = ((CB > FB) ? CB : FB) + 3;       // rounded + offset
  localparam int XPW = RW + fern_pkg::CFG_W + 1;        // scaling product
  localparam int NW  = XPW + 1;                         // pixel numerator
  localparam int DN  = SB + 4;                          // divide-by-10 input
  localparam int DK  = SB + 8;                          // reciprocal shift
  localparam int DMW = DK - 3;                          // reciprocal width

  localparam longint OFS_160 = ((longint'(8) << FB) + 2) / 5;
  localparam longint OFS_044 = ((longint'(11) << FB) + 12) / 25;
  localparam longint OFS_025 = longint'(1) << (FB - 2);
  localparam longint DIV_M   = ((longint'(1) << DK) + 9) / 10;

  localparam logic signed [RW-1:0]  OY_160    = RW'(OFS_160);
  localparam logic signed [RW-1:0]  OY_044    = RW'(OFS_044);
  localparam logic signed [RW-1:0]  X_BIAS    = RW'(OFS_025);
  localparam logic signed [RW-1:0]  COORD_MAX = RW'((longint'(1) << (CB - 1)) - 1);
  localparam logic signed [RW-1:0]  COORD_MIN = RW'(-(longint'(1) << (CB - 1)));
  localparam logic signed [SW-1:0]  RND_HALF  = SW'(longint'(1) << (fern_pkg::COEF_FRAC - 1));
  localparam logic signed [NW-1:0]  NEG_TEN   = NW'(-10);
  localparam logic signed [NW-1:0]  PIX_LIM   = NW'(longint'(10) << SB);
  localparam logic        [DMW-1:0] RECIP_10  = DMW'(DIV_M);

  // plot registers
  logic [fern_pkg::CFG_W-1:0] left_q, top_q, size_q;

  // point state
  logic signed [CB-1:0] point_x_q, point_y_q;

  // per-request pipeline registers
  fern_pkg::map_e        map_q;
  logic signed [PW-1:0]  prod_xx_q, prod_xy_q, prod_yx_q, prod_yy_q;
  logic signed [XPW-1:0] scl_x_q, scl_y_q;
  logic signed [NW-1:0]  num_x_q, num_y_q;
  logic [SB-1:0]         pixel_x_q, pixel_y_q;
  logic                  clamped_q;

  fern_pkg::map_e        map_d;
  fern_pkg::coef_t       coef;
  logic signed [SW-1:0]  sum_x, sum_y, rsh_x, rsh_y;
  logic signed [RW-1:0]  rnd_x, rnd_y, oy, new_y;
  logic signed [CB-1:0]  point_x_d, point_y_d;
  logic signed [RW-1:0]  x_off;
  logic signed [XPW-1:0] size_s, neg_scl_y, shf_x, shf_y;
  logic [16:0]           base_x, base_y;
  logic [12:0]           top_plus_size;
  logic signed [NW-1:0]  num_x_d, num_y_d;
  logic [SB:0]           pix_x, pix_y;

  function automatic logic signed [CB-1:0] sat_coord(input logic signed [RW-1:0] v);
    logic signed [CB-1:0] r;
    priority if (v > COORD_MAX) r = COORD_MAX[CB-1:0];
    else if (v < COORD_MIN)     r = COORD_MIN[CB-1:0];
    else                        r = v[CB-1:0];
    return r;
  endfunction

  // {clamp, pixel}: truncate h/10 toward zero, clamp to screen range
  function automatic logic [SB:0] to_pixel(input logic signed [NW-1:0] h);
    logic [DN-1:0]     n;
    logic [DN+DMW-1:0] p;
    logic [SB:0]       r;
    n = h[DN-1:0];
    p = n * RECIP_10;
    priority if (h < 0)   r = {(h <= NEG_TEN), {SB{1'b0}}};
    else if (h >= PIX_LIM) r = {1'b1, {SB{1'b1}}};
    else                   r = {1'b0, p[DK+SB-1:DK]};
    return r;
  endfunction

  // load: map select and point products
  assign map_d = fern_pkg::pick_to_map(random_pick_i);
  assign coef  = fern_pkg::map_coef(map_d);

  // point: exact sum, round half up at 16 bits, offset, saturate
  assign sum_x = SW'(prod_xx_q) + SW'(prod_xy_q);
  assign sum_y = SW'(prod_yx_q) + SW'(prod_yy_q);
  assign rsh_x = (sum_x + RND_HALF) >>> fern_pkg::COEF_FRAC;
  assign rsh_y = (sum_y + RND_HALF) >>> fern_pkg::COEF_FRAC;
  assign rnd_x = rsh_x[RW-1:0];
  assign rnd_y = rsh_y[RW-1:0];

  always_comb begin
    unique case (map_q)
      fern_pkg::MAP_STEM:  oy = '0;
      fern_pkg::MAP_MAIN:  oy = OY_160;
      fern_pkg::MAP_LEFT:  oy = OY_160;
      fern_pkg::MAP_RIGHT: oy = OY_044;
      default:             oy = '0;
    endcase
  end

  assign new_y     = rnd_y + oy;
  assign point_x_d = sat_coord(rnd_x);
  assign point_y_d = sat_coord(new_y);

  // scale: (x - 0.25) * size and y * size
  assign x_off  = RW'(point_x_q) - X_BIAS;
  assign size_s = $signed(XPW'(size_q));

  // num: integer parts of the pixel numerators, already divided by 2^FB
  assign base_x        = 17'({left_q, 3'b000}) + 17'({left_q, 1'b0})
                       + 17'({size_q, 2'b00}) + 17'(size_q);
  assign top_plus_size = 13'(top_q) + 13'(size_q);
  assign base_y        = 17'({top_plus_size, 3'b000}) + 17'({top_plus_size, 1'b0});
  assign neg_scl_y     = -scl_y_q;
  assign shf_x         = scl_x_q >>> FB;
  assign shf_y         = neg_scl_y >>> FB;
  assign num_x_d       = $signed(NW'(base_x)) + NW'(shf_x);
  assign num_y_d       = $signed(NW'(base_y)) + NW'(shf_y);

  // emit
  assign pix_x = to_pixel(num_x_q);
  assign pix_y = to_pixel(num_y_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q    <= fern_pkg::PLOT_LEFT_RST;
      top_q     <= fern_pkg::PLOT_TOP_RST;
      size_q    <= fern_pkg::PLOT_SIZE_RST;
      point_x_q <= '0;
      point_y_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          fern_pkg::CFG_PLOT_LEFT: left_q <= cfg_wdata_i;
          fern_pkg::CFG_PLOT_TOP:  top_q  <= cfg_wdata_i;
          fern_pkg::CFG_PLOT_SIZE: size_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (cmd_i.point) begin
        point_x_q <= point_x_d;
        point_y_q <= point_y_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      map_q     <= map_d;
      prod_xx_q <= PW'(coef.xx) * PW'(point_x_q);
      prod_xy_q <= PW'(coef.xy) * PW'(point_y_q);
      prod_yx_q <= PW'(coef.yx) * PW'(point_x_q);
      prod_yy_q <= PW'(coef.yy) * PW'(point_y_q);
    end
    if (cmd_i.scale) begin
      scl_x_q <= XPW'(x_off) * size_s;
      scl_y_q <= XPW'(point_y_q) * size_s;
    end
    if (cmd_i.num) begin
      num_x_q <= num_x_d;
      num_y_q <= num_y_d;
    end
    if (cmd_i.emit) begin
      pixel_x_q <= pix_x[SB-1:0];
      pixel_y_q <= pix_y[SB-1:0];
      clamped_q <= pix_x[SB] | pix_y[SB];
    end
  end

  assign pixel_x_o = pixel_x_q;
  assign pixel_y_o = pixel_y_q;
  assign clamped_o = clamped_q;

endmodule

`default_nettype wire

>>> hdl/fern_ifs_point_generator_unit.sv
// ----------------------------------------------------------------------------
// Fern IFS point generator
// Barnsley fern iterated function system step with screen pixel mapping.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  in_ch    in   valid/ready    random_pick[6:0]
//  out_ch   out  valid/ready    pixel_x, pixel_y [SCREEN_BITS], clamped
//  cfg      in   cfg_we_i       cfg_idx_i[1:0], cfg_wdata_i[11:0]
//
//  Per request, in order: point products, point update, scaling products,
//  numerators, then divide and clamp into the output register. The chain
//  of dependent multiplies through the shared point registers keeps one
//  request in flight; a new request is taken in the same cycle a result
//  leaves. Reset loads the plot defaults and puts the point at the origin.
//  A waiting result holds the last step; the next request waits for it.
// ----------------------------------------------------------------------------
`default_nettype none

module fern_ifs_point_generator_unit #(
  parameter int COORD_BITS  = 24,
  parameter int FRAC_BITS   = 16,
  parameter int SCREEN_BITS = 12
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  fern_pick_if.sink                            in_ch,
  fern_pixel_if.source                         out_ch,
  input  wire logic                            cfg_we_i,
  input  wire logic [fern_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [fern_pkg::CFG_W-1:0]      cfg_wdata_i
);

  fern_pkg::ctl_cmd_t     cmd;
  logic                   in_ready;
  logic                   out_valid;
  logic [SCREEN_BITS-1:0] pixel_x, pixel_y;
  logic                   clamped;

  // sequencer: one request at a time, output register decoupled
  fern_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_ch.ready),
    .cmd_o       (cmd)
  );

  // arithmetic, point state, plot registers and result payload
  fern_dp #(
    .COORD_BITS  (COORD_BITS),
    .FRAC_BITS   (FRAC_BITS),
    .SCREEN_BITS (SCREEN_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .random_pick_i (in_ch.random_pick),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .pixel_x_o     (pixel_x),
    .pixel_y_o     (pixel_y),
    .clamped_o     (clamped)
  );

  assign in_ch.ready    = in_ready;
  assign out_ch.valid   = out_valid;
  assign out_ch.pixel_x = pixel_x;
  assign out_ch.pixel_y = pixel_y;
  assign out_ch.clamped = clamped;

endmodule

`default_nettype wire
